[hdl/turn_indicator_arbiter_top_defines.svh]
// Assertion macros used by the turn indicator arbiter RTL.
`ifndef TURN_INDICATOR_ARBITER_TOP_DEFINES_SVH
`define TURN_INDICATOR_ARBITER_TOP_DEFINES_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication, disabled in reset
`define TIA_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tia assertion failed");

// Next-cycle implication, disabled in reset
`define TIA_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tia assertion failed");

`else

`define TIA_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define TIA_ASSERT_NXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

[hdl/tia_pkg.sv]
// Types and constants of the turn indicator arbiter.
`timescale 1ns / 1ps

package tia_pkg;

    // Owner codes, as seen on the result stream
    typedef enum logic [1:0] {
        MODE_IDLE   = 2'd0,
        MODE_LEFT   = 2'd1,
        MODE_RIGHT  = 2'd2,
        MODE_HAZARD = 2'd3
    } t_mode;

    // Configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] REG_LEFT_PERIOD   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RIGHT_PERIOD  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_HAZARD_PERIOD = 2'd2;

    localparam int PERIOD_W = 8;
    localparam logic [PERIOD_W-1:0] LEFT_PERIOD_RST   = 8'd2;
    localparam logic [PERIOD_W-1:0] RIGHT_PERIOD_RST  = 8'd1;
    localparam logic [PERIOD_W-1:0] HAZARD_PERIOD_RST = 8'd1;

    // Switch / counter slots
    localparam int SW_LEFT   = 0;
    localparam int SW_RIGHT  = 1;
    localparam int SW_HAZARD = 2;

endpackage

[hdl/turn_indicator_arbiter_top.sv]
// Turn indicator arbiter: switch edge arbitration and lamp blinking per tick.
//
//  channel     | dir | payload (lsb first)                         | accept
//  ------------+-----+---------------------------------------------+-------------------
//  s_axis      | in  | tdata: left_level, right_level, hazard_level | tvalid & tready
//  m_axis      | out | tdata: left_lamp, right_lamp, active_mode    | tvalid & tready
//  cfg         | in  | index (2b), data (8b period)                 | valid & ready
//
// One tick per cycle sustained while results are taken; each result passes the input
// register, then the result register. Both state update and the lamp logic sit
// between those two registers.
// A stalled result holds the pipe; the input register still fills once.
// Reset is synchronous, active low; config registers take their defaults.
// The config port is always ready.
`timescale 1ns / 1ps
`include "turn_indicator_arbiter_top_defines.svh"

module turn_indicator_arbiter_top
    import tia_pkg::*;
#(
    parameter int COUNT_WIDTH = 8
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // tick request
    input  logic                 i_s_axis_tvalid,
    output logic                 o_s_axis_tready,
    input  logic [7:0]           i_s_axis_tdata,   // [0] left_level, [1] right_level,
                                                   // [2] hazard_level, [7:3] zero
    // result
    output logic                 o_m_axis_tvalid,
    input  logic                 i_m_axis_tready,
    output logic [7:0]           o_m_axis_tdata,   // [0] left_lamp, [1] right_lamp,
                                                   // [3:2] active_mode, [7:4] zero
    // configuration writes
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [PERIOD_W-1:0]  i_cfg_data
);

    localparam int CMP_W = (COUNT_WIDTH > PERIOD_W) ? COUNT_WIDTH : PERIOD_W;
    localparam logic [CMP_W-1:0] CNT_MAX = CMP_W'((1 << COUNT_WIDTH) - 1);

    typedef logic [COUNT_WIDTH-1:0] t_cnt;

    // configuration
    logic [PERIOD_W-1:0] r_left_period;
    logic [PERIOD_W-1:0] r_right_period;
    logic [PERIOD_W-1:0] r_hazard_period;

    // pipeline
    logic       r_in_valid;
    logic [2:0] r_in_lvl;
    logic       r_out_valid;
    logic [1:0] r_out_lamp;
    t_mode      r_out_mode;
    logic       w_advance;
    logic       w_step;

    // arbiter state
    logic [2:0] r_prev;
    logic [2:0] r_sup;
    t_mode      r_mode;
    logic [1:0] r_lamp;
    t_cnt       r_cnt [3];

    logic [2:0] n_sup;
    t_mode      n_mode;
    logic [1:0] n_lamp;
    t_cnt       n_cnt [3];

    logic [2:0]          w_rise;
    logic [2:0]          w_fall;
    t_cnt                w_cur;
    t_cnt                w_inc;
    logic [PERIOD_W-1:0] w_period;
    logic [CMP_W-1:0]    w_eff;
    logic                w_due;

    assign o_cfg_ready = 1'b1;

    // Write configuration registers; unknown indexes are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left_period   <= LEFT_PERIOD_RST;
            r_right_period  <= RIGHT_PERIOD_RST;
            r_hazard_period <= HAZARD_PERIOD_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_LEFT_PERIOD:   r_left_period   <= i_cfg_data;
                REG_RIGHT_PERIOD:  r_right_period  <= i_cfg_data;
                REG_HAZARD_PERIOD: r_hazard_period <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Pipeline flow control
    assign w_advance       = !r_out_valid || i_m_axis_tready;
    assign w_step          = r_in_valid && w_advance;
    assign o_s_axis_tready = !r_in_valid || w_advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_axis_tready) begin
            r_in_valid <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_axis_tready && i_s_axis_tvalid) begin
            r_in_lvl <= i_s_axis_tdata[2:0];
        end
    end

    // Edge detection against the previous tick
    assign w_rise = r_in_lvl & ~r_prev;
    assign w_fall = ~r_in_lvl & r_prev;

    // Arbitrate ownership, then pick the owner's counter for the blink step
    always_comb begin
        n_sup  = r_sup & ~w_fall;
        n_mode = r_mode;
        n_lamp = r_lamp;
        n_cnt  = r_cnt;

        if (w_rise[SW_LEFT] && !n_sup[SW_LEFT]) begin
            n_mode             = MODE_LEFT;
            n_sup              = n_sup | 3'b110;
            n_cnt[SW_LEFT]     = '0;
            n_lamp[SW_RIGHT]   = 1'b0;
        end
        if (w_rise[SW_RIGHT] && !n_sup[SW_RIGHT]) begin
            n_mode             = MODE_RIGHT;
            n_sup              = n_sup | 3'b101;
            n_cnt[SW_RIGHT]    = '0;
            n_lamp[SW_LEFT]    = 1'b0;
        end
        if (w_rise[SW_HAZARD] && !n_sup[SW_HAZARD]) begin
            n_mode             = MODE_HAZARD;
            n_sup              = n_sup | 3'b011;
            n_cnt[SW_HAZARD]   = '0;
        end

        // Release of the owner's switch drops to idle
        if ((n_mode == MODE_LEFT   && w_fall[SW_LEFT])  ||
            (n_mode == MODE_RIGHT  && w_fall[SW_RIGHT]) ||
            (n_mode == MODE_HAZARD && w_fall[SW_HAZARD])) begin
            n_mode = MODE_IDLE;
        end

        case (n_mode)
            MODE_LEFT: begin
                w_cur    = n_cnt[SW_LEFT];
                w_period = r_left_period;
            end
            MODE_RIGHT: begin
                w_cur    = n_cnt[SW_RIGHT];
                w_period = r_right_period;
            end
            default: begin
                w_cur    = n_cnt[SW_HAZARD];
                w_period = r_hazard_period;
            end
        endcase

        // Saturating increment against the clamped period
        w_inc = (CMP_W'(w_cur) == CNT_MAX) ? w_cur : w_cur + t_cnt'(1);
        w_eff = (CMP_W'(w_period) > CNT_MAX) ? CNT_MAX : CMP_W'(w_period);
        w_due = CMP_W'(w_inc) >= w_eff;

        case (n_mode)
            MODE_LEFT: begin
                n_lamp[SW_RIGHT] = 1'b0;
                if (w_due) begin
                    n_lamp[SW_LEFT] = ~n_lamp[SW_LEFT];
                end
                n_cnt[SW_LEFT] = w_due ? '0 : w_inc;
            end
            MODE_RIGHT: begin
                n_lamp[SW_LEFT] = 1'b0;
                if (w_due) begin
                    n_lamp[SW_RIGHT] = ~n_lamp[SW_RIGHT];
                end
                n_cnt[SW_RIGHT] = w_due ? '0 : w_inc;
            end
            MODE_HAZARD: begin
                if (w_due) begin
                    n_lamp = n_lamp[SW_LEFT] ? 2'b00 : 2'b11;
                end
                n_cnt[SW_HAZARD] = w_due ? '0 : w_inc;
            end
            default: begin
                n_lamp = 2'b00;
                n_cnt  = '{default: '0};
            end
        endcase
    end

    // Commit state on each tick
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev <= '0;
            r_sup  <= '0;
            r_mode <= MODE_IDLE;
            r_lamp <= '0;
            r_cnt  <= '{default: '0};
        end else if (w_step) begin
            r_prev <= r_in_lvl;
            r_sup  <= n_sup;
            r_mode <= n_mode;
            r_lamp <= n_lamp;
            r_cnt  <= n_cnt;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_step) begin
            r_out_lamp <= n_lamp;
            r_out_mode <= n_mode;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {4'b0000, r_out_mode, r_out_lamp};

    // Idle owner keeps lamps dark and counters cleared
    `TIA_ASSERT_IMP(a_idle_dark, i_clk, i_rst_n, r_mode == MODE_IDLE, r_lamp == 2'b00 && r_cnt[SW_LEFT] == '0 && r_cnt[SW_RIGHT] == '0 && r_cnt[SW_HAZARD] == '0)
    // Left owner never lights the right lamp
    `TIA_ASSERT_IMP(a_left_only, i_clk, i_rst_n, r_mode == MODE_LEFT, !r_lamp[SW_RIGHT])
    // Right owner never lights the left lamp
    `TIA_ASSERT_IMP(a_right_only, i_clk, i_rst_n, r_mode == MODE_RIGHT, !r_lamp[SW_LEFT])
    // A pending result always mirrors the committed state
    `TIA_ASSERT_IMP(a_out_state, i_clk, i_rst_n, r_out_valid, r_out_mode == r_mode && r_out_lamp == r_lamp)
    // A processed tick always leaves a result pending
    `TIA_ASSERT_NXT(a_step_out, i_clk, i_rst_n, w_step, r_out_valid)

endmodule

[tb/tb_top.sv]
// Self-checking testbench of the turn indicator arbiter: switch ticks in, lamp states out.
`timescale 1ns / 1ps

module tb_top;
    import tia_pkg::*;

    localparam int CNT_W = 8;
    localparam logic [CNT_W-1:0] CNT_MAX = '1;
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
    localparam int DRAIN_CYCLES = 4;

    // One lamp state as the block reports it
    typedef struct {
        logic  left_lamp;
        logic  right_lamp;
        t_mode mode;
    } t_lamp_state;

    // Tracks switch ownership and blink phase, and holds the lamp states still owed
    class lamp_tracker;
        logic [PERIOD_W-1:0] period [3];
        logic [2:0]          prev_lv;
        logic [2:0]          supp;
        t_mode               owner;
        logic [1:0]          lamps;
        logic [CNT_W-1:0]    cnt [3];
        t_lamp_state         owed_q [$];
        int                  errors;

        function new();
            period[SW_LEFT]   = LEFT_PERIOD_RST;
            period[SW_RIGHT]  = RIGHT_PERIOD_RST;
            period[SW_HAZARD] = HAZARD_PERIOD_RST;
            prev_lv = '0;
            supp    = '0;
            owner   = MODE_IDLE;
            lamps   = '0;
            foreach (cnt[k]) cnt[k] = '0;
            errors  = 0;
        endfunction

        function void set_period(logic [CFG_IDX_W-1:0] idx, logic [PERIOD_W-1:0] val);
            case (idx)
                REG_LEFT_PERIOD:   period[SW_LEFT]   = val;
                REG_RIGHT_PERIOD:  period[SW_RIGHT]  = val;
                REG_HAZARD_PERIOD: period[SW_HAZARD] = val;
                default: ;
            endcase
        endfunction

        // Advance one blink counter; report a due toggle
        function bit blink_due(int k);
            logic [CNT_W-1:0] lim;
            lim = (period[k] > CNT_MAX) ? CNT_MAX : CNT_W'(period[k]);
            if (cnt[k] != CNT_MAX) cnt[k] = cnt[k] + CNT_W'(1);
            if (cnt[k] >= lim) begin
                cnt[k] = '0;
                return 1'b1;
            end
            return 1'b0;
        endfunction

        function void tick_accepted(logic [2:0] lv);
            logic [2:0]  rise;
            logic [2:0]  fall;
            t_lamp_state st;
            rise = lv & ~prev_lv;
            fall = ~lv & prev_lv;
            supp = supp & ~fall;

            // Arbitrate presses, left first
            if (rise[SW_LEFT] && !supp[SW_LEFT]) begin
                owner = MODE_LEFT;
                supp  = supp | 3'b110;
                cnt[SW_LEFT] = '0;
                lamps[1] = 1'b0;
            end
            if (rise[SW_RIGHT] && !supp[SW_RIGHT]) begin
                owner = MODE_RIGHT;
                supp  = supp | 3'b101;
                cnt[SW_RIGHT] = '0;
                lamps[0] = 1'b0;
            end
            if (rise[SW_HAZARD] && !supp[SW_HAZARD]) begin
                owner = MODE_HAZARD;
                supp  = supp | 3'b011;
                cnt[SW_HAZARD] = '0;
            end

            // Drop ownership when the owner's switch is released
            if ((owner == MODE_LEFT && fall[SW_LEFT]) ||
                (owner == MODE_RIGHT && fall[SW_RIGHT]) ||
                (owner == MODE_HAZARD && fall[SW_HAZARD]))
                owner = MODE_IDLE;

            case (owner)
                MODE_LEFT: begin
                    lamps[1] = 1'b0;
                    if (blink_due(SW_LEFT)) lamps[0] = ~lamps[0];
                end
                MODE_RIGHT: begin
                    lamps[0] = 1'b0;
                    if (blink_due(SW_RIGHT)) lamps[1] = ~lamps[1];
                end
                MODE_HAZARD: begin
                    if (blink_due(SW_HAZARD)) lamps = lamps[0] ? 2'b00 : 2'b11;
                end
                default: begin
                    lamps = '0;
                    foreach (cnt[k]) cnt[k] = '0;
                end
            endcase
            prev_lv = lv;

            st.left_lamp  = lamps[0];
            st.right_lamp = lamps[1];
            st.mode       = owner;
            owed_q.push_back(st);
        endfunction

        function void lamps_seen(logic [7:0] data);
            t_lamp_state st;
            if (owed_q.size() == 0) begin
                $display("%0t: result with none owed, expected nothing, actual tdata=%h",
                         $time, data);
                errors++;
                return;
            end
            st = owed_q.pop_front();
            if (data[0] !== st.left_lamp) begin
                $display("%0t: left_lamp expected %0b actual %0b", $time, st.left_lamp, data[0]);
                errors++;
            end
            if (data[1] !== st.right_lamp) begin
                $display("%0t: right_lamp expected %0b actual %0b", $time, st.right_lamp,
                         data[1]);
                errors++;
            end
            if (data[3:2] !== st.mode) begin
                $display("%0t: active_mode expected %0d actual %0d", $time, st.mode, data[3:2]);
                errors++;
            end
        endfunction
    endclass

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_s_axis_tvalid;
    logic                 o_s_axis_tready;
    logic [7:0]           i_s_axis_tdata;
    logic                 o_m_axis_tvalid;
    logic                 i_m_axis_tready;
    logic [7:0]           o_m_axis_tdata;
    logic                 i_cfg_valid;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [PERIOD_W-1:0]  i_cfg_data;

    lamp_tracker tracker = new();
    logic [2:0]  lv_now;
    bit          idle_on;
    bit          hold_off_req;

    turn_indicator_arbiter_top #(
        .COUNT_WIDTH(CNT_W)
    ) DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_s_axis_tvalid(i_s_axis_tvalid),
        .o_s_axis_tready(o_s_axis_tready),
        .i_s_axis_tdata (i_s_axis_tdata),
        .o_m_axis_tvalid(o_m_axis_tvalid),
        .i_m_axis_tready(i_m_axis_tready),
        .o_m_axis_tdata (o_m_axis_tdata),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    // 10 ns clock
    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // Offer one tick request; return on the edge that takes it
    task automatic send_tick(logic [2:0] lv);
        if (idle_on && $urandom_range(0, 7) == 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= {5'b0, lv};
        do @(negedge i_clk); while (!o_s_axis_tready);
        tracker.tick_accepted(lv);
        @(posedge i_clk);
    endtask

    // Stop offering and wait until every owed lamp state has come back
    task automatic drain();
        i_s_axis_tvalid <= 1'b0;
        while (tracker.owed_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [PERIOD_W-1:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(negedge i_clk); while (!o_cfg_ready);
        tracker.set_period(idx, val);
        @(posedge i_clk);
    endtask

    task automatic set_periods(logic [PERIOD_W-1:0] l, logic [PERIOD_W-1:0] r,
                               logic [PERIOD_W-1:0] h, bit poke_unused);
        drain();
        write_reg(REG_LEFT_PERIOD, l);
        write_reg(REG_RIGHT_PERIOD, r);
        write_reg(REG_HAZARD_PERIOD, h);
        if (poke_unused) write_reg(REG_UNUSED, 8'($urandom));
        i_cfg_valid <= 1'b0;
    endtask

    // Mostly press-hold-release sequences, with some noise ticks; may end mid-hold
    task automatic run_phase(int n_ticks, int long_hold);
        int sent;
        int kind;
        int s;
        int o;
        int hold;
        sent = 0;
        while (sent < n_ticks) begin
            kind = $urandom_range(0, 9);
            if (kind < 2) begin
                repeat ($urandom_range(1, 6)) begin
                    lv_now = 3'($urandom);
                    send_tick(lv_now);
                    sent++;
                end
            end else begin
                s = $urandom_range(0, 2);
                // release first so the press is a real rising edge
                if (lv_now[s]) begin
                    lv_now[s] = 1'b0;
                    send_tick(lv_now);
                    sent++;
                end
                if (kind == 2) lv_now = 3'($urandom) | (3'b001 << s);
                else lv_now[s] = 1'b1;
                hold = ($urandom_range(0, 7) == 0) ? $urandom_range(1, long_hold)
                                                   : $urandom_range(1, 12);
                for (int k = 0; k < hold && sent < n_ticks; k++) begin
                    if ($urandom_range(0, 5) == 0) begin
                        o = (s + $urandom_range(1, 2)) % 3;
                        lv_now[o] = ~lv_now[o];
                    end
                    send_tick(lv_now);
                    sent++;
                end
                if (sent < n_ticks) begin
                    lv_now[s] = 1'b0;
                    if ($urandom_range(0, 2) == 0) lv_now = '0;
                    send_tick(lv_now);
                    sent++;
                end
            end
        end
    endtask

    // Result side: random stall bursts, one long hold-off on request, check each result
    initial begin : result_sink
        int stall;
        stall = 0;
        i_m_axis_tready <= 1'b0;
        do @(posedge i_clk); while (!i_rst_n);
        forever begin
            if (hold_off_req) begin
                hold_off_req = 1'b0;
                stall = 300;
            end
            if (stall > 0) begin
                i_m_axis_tready <= 1'b0;
                stall--;
            end else begin
                i_m_axis_tready <= 1'b1;
                if (idle_on && $urandom_range(0, 7) == 0) stall = $urandom_range(1, 19);
            end
            @(negedge i_clk);
            if (o_m_axis_tvalid && i_m_axis_tready) tracker.lamps_seen(o_m_axis_tdata);
            @(posedge i_clk);
        end
    end

    // Watchdog
    initial begin
        #5_000_000;
        $display("tb_top: FAIL");
        $finish;
    end

    initial begin : stimulus
        logic [PERIOD_W-1:0] pl;
        logic [PERIOD_W-1:0] pr;
        logic [PERIOD_W-1:0] ph;
        i_rst_n         <= 1'b0;
        i_s_axis_tvalid <= 1'b0;
        i_s_axis_tdata  <= '0;
        i_cfg_valid     <= 1'b0;
        i_cfg_index     <= '0;
        i_cfg_data      <= '0;
        lv_now       = '0;
        idle_on      = 1'b0;
        hold_off_req = 1'b0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: reset periods, priority, suppression, release to idle
        send_tick(3'b000);
        send_tick(3'b001);   // left takes ownership
        send_tick(3'b001);
        send_tick(3'b001);
        send_tick(3'b011);   // right suppressed under left
        send_tick(3'b001);   // right release clears its suppression
        send_tick(3'b000);   // left release goes idle
        send_tick(3'b111);   // simultaneous press, left wins
        send_tick(3'b110);   // owner released with others still held
        send_tick(3'b000);
        send_tick(3'b110);   // right beats hazard
        send_tick(3'b110);
        send_tick(3'b100);
        send_tick(3'b000);
        send_tick(3'b100);   // hazard blinks both lamps
        send_tick(3'b100);
        send_tick(3'b100);
        send_tick(3'b101);   // left suppressed under hazard
        send_tick(3'b100);
        send_tick(3'b000);
        send_tick(3'b010);
        send_tick(3'b010);
        send_tick(3'b000);

        // Random phases over several period settings
        idle_on = 1'b1;
        run_phase(275, 10);

        set_periods(8'd1, 8'd1, 8'd1, 1'b1);
        idle_on = 1'b1;
        hold_off_req = 1'b1;
        run_phase(275, 8);

        set_periods(8'd255, 8'd255, 8'd255, 1'b0);
        idle_on = ($urandom_range(0, 3) != 0);
        run_phase(275, 2 * 255 + 4);

        // lowered period while a switch may still be held
        set_periods(8'd0, 8'd0, 8'd0, 1'b1);
        idle_on = ($urandom_range(0, 3) != 0);
        run_phase(275, 8);

        pl = 8'($urandom_range(1, 8));
        pr = 8'($urandom_range(1, 8));
        ph = 8'($urandom_range(1, 8));
        set_periods(pl, pr, ph, 1'b0);
        idle_on = 1'b1;
        run_phase(275, 20);

        set_periods(8'd3, 8'd255, 8'd7, 1'b0);
        idle_on = ($urandom_range(0, 3) != 0);
        run_phase(275, 2 * 255 + 4);

        pl = 8'($urandom_range(1, 20));
        pr = 8'($urandom_range(1, 20));
        ph = 8'($urandom_range(1, 20));
        set_periods(pl, pr, ph, 1'b0);
        idle_on = 1'b0;
        run_phase(275, 44);

        i_s_axis_tvalid <= 1'b0;
        while (tracker.owed_q.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (tracker.errors == 0)
            $display("tb_top: PASS");
        else
            $display("tb_top: FAIL");
        $finish;
    end

endmodule

[turn_indicator_arbiter_top.f]
+incdir+hdl
hdl/tia_pkg.sv
hdl/turn_indicator_arbiter_top.sv
tb/tb_top.sv
